@@ hdl/edb_pkg.sv @@
// Shared widths, register indexes, pixel modes and error arithmetic for the binarizer.
`timescale 1ns / 1ps

package edb_pkg;

	// Field and register widths
	localparam int PIX_W  = 8;
	localparam int ERR_W  = 10;
	localparam int SUM_W  = 12;
	localparam int PROD_W = 16;
	localparam int LW_W   = 11;
	localparam int IH_W   = 16;
	localparam int CIDX_W = 2;
	localparam int CDAT_W = 16;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// Reset values of the configuration registers
	localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 11'd640;
	localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

	// Quantizer levels
	localparam logic signed [SUM_W-1:0] THRESHOLD = 12'sd128;
	localparam logic signed [SUM_W-1:0] WHITE     = 12'sd255;

	// What one pixel does to the error state
	localparam logic [1:0] MODE_BORDER = 2'd0;
	localparam logic [1:0] MODE_FIRST  = 2'd1;
	localparam logic [1:0] MODE_MID    = 2'd2;
	localparam logic [1:0] MODE_LAST   = 2'd3;

	// Divide by 16, rounding toward zero
	function automatic logic signed [SUM_W-1:0] div16_tz(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + (v[PROD_W-1] ? 16'sd15 : 16'sd0);
		return t[PROD_W-1:4];
	endfunction

	// Clamp to the signed 10-bit error range
	function automatic logic signed [ERR_W-1:0] sat10(input logic signed [SUM_W-1:0] v);
		if (v < -12'sd512) begin
			return 10'sh200;
		end else if (v > 12'sd511) begin
			return 10'sh1FF;
		end
		return v[ERR_W-1:0];
	endfunction

endpackage

@@ hdl/edb_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module edb_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              re,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and read port that holds its data when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/error_diffusion_binarizer.sv @@
// Top level of the Floyd-Steinberg error diffusion binarizer.
`timescale 1ns / 1ps

// Takes one 8-bit grey pixel per clock in raster order while in_stall is low, and
// returns one pixel per pixel: 0 or 255 for inner pixels, the input value unchanged
// on the border rows and columns. Throughput is one pixel every clock unless the
// output stalls; pixels pass the input register, then the result register, and the
// only per-pixel feedback is the error carried to the right neighbor. Pending errors
// for the next row sit in MAX_LINE/LANES-deep RAMs, one per lane, with one valid bit
// per RAM row; the last pixel of an image drops every valid bit together, so no clearing
// pass is needed and the next image can start at once. line_width and image_height
// may be written whenever no pixel is in flight; a width keeps only its low 11 bits, and
// out-of-range values act as the nearest legal value (width 3..MAX_LINE, height at least 3).
module error_diffusion_binarizer
	import edb_pkg::*;
#(
	parameter int MAX_LINE = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CDAT_W-1:0] cfg_data,
	// pixel input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  pixel_in,
	// pixel output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  pixel_out
);

	localparam int IDX_W     = $clog2(MAX_LINE);
	localparam int W_W       = $clog2(MAX_LINE + 1);
	localparam int LANE_BITS = (IDX_W > 8) ? IDX_W - 8 : 0;
	localparam int LANE_W    = (LANE_BITS > 0) ? LANE_BITS : 1;
	localparam int LANES     = 1 << LANE_BITS;
	localparam int GROUPS    = (MAX_LINE + LANES - 1) / LANES;
	localparam int GA_W      = $clog2(GROUPS);

	// Configuration registers
	logic [LW_W-1:0] line_width_q;
	logic [IH_W-1:0] image_height_q;

	// Position and handshake
	logic [IDX_W-1:0] col_q;
	logic [IH_W-1:0]  row_q;
	logic             accept;
	logic             s1_valid_q;
	logic             s1_go;
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;

	// Front-end decode
	logic [W_W-1:0]   w_eff;
	logic [W_W-1:0]   w_m1;
	logic [IH_W-1:0]  h_m1;
	logic             inner_row;
	logic             last_col;
	logic             last_row;
	logic             img_clear;
	logic [1:0]       mode_nx;
	logic             wr_en_nx;
	logic [IDX_W-1:0] wr_idx_nx;

	// Input stage
	logic [PIX_W-1:0]  pix_s1;
	logic [1:0]        mode_s1;
	logic              wr_en_s1;
	logic [LANE_W-1:0] wr_lane_s1;
	logic [GA_W-1:0]   wr_grp_s1;
	logic [LANE_W-1:0] rd_lane_s1;
	logic              rd_vld_s1;

	// Error state
	logic signed [ERR_W-1:0] carry_q;
	logic signed [ERR_W-1:0] bprev_q;
	logic signed [ERR_W-1:0] bhere_q;
	logic [GROUPS-1:0]       grp_valid_q;

	// Error line store
	logic [ERR_W-1:0] rd_lane [LANES];
	logic [LANES-1:0] lane_we;
	logic [ERR_W-1:0] lane_wd [LANES];
	logic [GA_W-1:0]  rd_grp;
	logic             grp_hit;

	// Datapath
	logic signed [ERR_W-1:0]  line_val;
	logic signed [SUM_W-1:0]  sum;
	logic                     q_white;
	logic signed [SUM_W-1:0]  err;
	logic signed [SUM_W-1:0]  e7;
	logic signed [SUM_W-1:0]  e5;
	logic signed [SUM_W-1:0]  e3;
	logic signed [SUM_W-1:0]  e1;
	logic signed [ERR_W-1:0]  wr_val;
	logic [PIX_W-1:0]         result;

	assign cfg_ready = 1'b1;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINE_WIDTH:   line_width_q   <= cfg_data[LW_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[IH_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register frees up
	assign s1_go    = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_go;
	assign accept   = in_valid && !in_stall;

	// Clamp the geometry and classify the incoming pixel
	always_comb begin
		if (line_width_q < 11'd3) begin
			w_eff = W_W'(3);
		end else if (32'(line_width_q) > MAX_LINE) begin
			w_eff = W_W'(MAX_LINE);
		end else begin
			w_eff = W_W'(line_width_q);
		end
		w_m1 = w_eff - W_W'(1);
		h_m1 = ((image_height_q < 16'd3) ? 16'd3 : image_height_q) - 16'd1;

		inner_row = (row_q != '0) && (row_q < h_m1);
		last_col  = (W_W'(col_q) >= w_m1);
		last_row  = (row_q >= h_m1);
		img_clear = accept && last_col && last_row;

		if (!inner_row) begin
			mode_nx = MODE_BORDER;
		end else if (col_q == '0) begin
			mode_nx = MODE_FIRST;
		end else if (last_col) begin
			mode_nx = MODE_LAST;
		end else begin
			mode_nx = MODE_MID;
		end

		// Mid pixels settle the entry behind them, the row end settles the last inner column
		wr_en_nx  = (mode_nx == MODE_LAST) || ((mode_nx == MODE_MID) && (col_q >= IDX_W'(2)));
		wr_idx_nx = (mode_nx == MODE_LAST) ? IDX_W'(w_eff - W_W'(2)) : (col_q - IDX_W'(1));
		rd_grp    = GA_W'(col_q / LANES);
	end

	// Advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Input stage payload; the store read is issued in the same beat
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixel_in;
			mode_s1    <= mode_nx;
			wr_en_s1   <= wr_en_nx;
			wr_lane_s1 <= LANE_W'(wr_idx_nx % LANES);
			wr_grp_s1  <= GA_W'(wr_idx_nx / LANES);
			rd_lane_s1 <= LANE_W'(col_q % LANES);
			rd_vld_s1  <= grp_valid_q[rd_grp];
		end
	end

	// Row valid bits: drop all at image end, set on first write to a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= '0;
		end else if (img_clear) begin
			grp_valid_q <= '0;
		end else if (s1_go && wr_en_s1) begin
			grp_valid_q[wr_grp_s1] <= 1'b1;
		end
	end

	assign grp_hit = grp_valid_q[wr_grp_s1];

	// One RAM per lane; a write to a stale row zeroes the other lanes of that row
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign lane_we[l] = s1_go && wr_en_s1 && (!grp_hit || (wr_lane_s1 == LANE_W'(l)));
		assign lane_wd[l] = (wr_lane_s1 == LANE_W'(l)) ? wr_val : '0;

		edb_ram #(
			.WIDTH(ERR_W),
			.DEPTH(GROUPS)
		) u_ram (
			.clk     (clk),
			.we      (lane_we[l]),
			.wr_addr (wr_grp_s1),
			.wr_data (lane_wd[l]),
			.re      (accept),
			.rd_addr (rd_grp),
			.rd_data (rd_lane[l])
		);
	end

	// Quantize and split the error
	always_comb begin
		line_val = '0;
		for (int l = 0; l < LANES; l++) begin
			if (rd_lane_s1 == LANE_W'(l)) begin
				line_val = rd_vld_s1 ? rd_lane[l] : '0;
			end
		end

		sum     = $signed({4'b0000, pix_s1}) + SUM_W'(line_val) + SUM_W'(carry_q);
		q_white = (sum >= THRESHOLD);
		err     = sum - (q_white ? WHITE : 12'sd0);

		e7 = div16_tz(PROD_W'(err) * 16'sd7);
		e5 = div16_tz(PROD_W'(err) * 16'sd5);
		e3 = div16_tz(PROD_W'(err) * 16'sd3);
		e1 = div16_tz(PROD_W'(err));

		if (mode_s1 == MODE_LAST) begin
			wr_val = bprev_q;
		end else begin
			wr_val = sat10(SUM_W'(bprev_q) + e3);
		end

		result = (mode_s1 == MODE_MID) ? (q_white ? PIX_W'(255) : '0) : pix_s1;
	end

	// Update the running errors as the pixel leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			bprev_q <= '0;
			bhere_q <= '0;
		end else if (s1_go) begin
			case (mode_s1)
				MODE_FIRST: begin
					carry_q <= '0;
					bprev_q <= '0;
					bhere_q <= '0;
				end
				MODE_MID: begin
					carry_q <= sat10(e7);
					bprev_q <= sat10(SUM_W'(bhere_q) + e5);
					bhere_q <= sat10(e1);
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			pixel_out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

`ifndef ASSERT_OFF
	// A dithered inner pixel is always black or white
	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && mode_s1 == MODE_MID) |-> (result == '0 || result == PIX_W'(255)))
		else $error("inner pixel not binary");

	// The last pixel of an image leaves no pending error behind
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		img_clear |=> (grp_valid_q == '0 && col_q == '0 && row_q == '0))
		else $error("error line not cleared at image end");

	// Stall is raised only while the input stage holds a pixel
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("stall without a held pixel");

	// Row end write always lands on the last inner column
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_nx == MODE_LAST) |-> (W_W'(wr_idx_nx) == w_eff - W_W'(2)))
		else $error("row end write misplaced");
`endif

endmodule

@@ tb/error_diffusion_binarizer_test.sv @@
// Self-checking testbench for the error diffusion binarizer: directed table, then random images.
`timescale 1ns / 1ps

module error_diffusion_binarizer_test;
	import edb_pkg::*;

	localparam int MAX_LINE      = 1024;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int HOLD_CYCLES   = 120;
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP     = 100;
	localparam int N_DIRECTED    = 34;

	// Register index with no register behind it
	localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

	// Row kinds of the directed table
	localparam logic ROW_PIX = 1'b0;
	localparam logic ROW_CFG = 1'b1;

	typedef enum int {PAT_NOISE, PAT_MID, PAT_EXTREME, PAT_RAMP} pattern_t;

	typedef struct packed {
		logic              is_cfg;
		logic [CIDX_W-1:0] idx;
		logic [CDAT_W-1:0] val;
		logic [PIX_W-1:0]  pix;
		logic              known;
		logic [PIX_W-1:0]  want;
	} step_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CDAT_W-1:0] cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [PIX_W-1:0]  pixel_in  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PIX_W-1:0]  pixel_out;

	// Dithered pixels still owed by the block, oldest first
	logic [PIX_W-1:0] pending_pixels [$];
	int               mismatch_count = 0;
	bit               tx_gaps = 1'b1;
	bit               rx_gaps = 1'b1;
	bit               hold_req = 1'b0;

	// Shadow of the block: configuration, position and diffused errors
	logic [LW_W-1:0]         width_reg  = LINE_WIDTH_RST;
	logic [IH_W-1:0]         height_reg = IMAGE_HEIGHT_RST;
	logic signed [ERR_W-1:0] err_row [MAX_LINE];
	logic signed [ERR_W-1:0] carry_err  = '0;
	logic signed [ERR_W-1:0] below_left = '0;
	logic signed [ERR_W-1:0] below_mid  = '0;
	logic [9:0]              col_pos = '0;
	logic [15:0]             row_pos = '0;

	// Directed table: reset geometry, extremes of width and height, threshold edge,
	// row-end writes, image wrap and geometry changes in the middle of an image
	step_t directed_steps [N_DIRECTED] = '{
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h00, 1'b1, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'hFF, 1'b1, 8'hFF},
		'{ROW_CFG, CFG_LINE_WIDTH,   16'd3,    8'h00, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h80, 1'b1, 8'h80},
		'{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd0,    8'h00, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h55, 1'b1, 8'h55},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h80, 1'b1, 8'hFF},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h7F, 1'b1, 8'h7F},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h01, 1'b1, 8'h01},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'hFE, 1'b1, 8'hFE},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h10, 1'b1, 8'h10},
		'{ROW_CFG, CFG_LINE_WIDTH,   16'hF804, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd4,    8'h00, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h20, 1'b1, 8'h20},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h40, 1'b1, 8'h40},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h60, 1'b1, 8'h60},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h81, 1'b1, 8'h81},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h00, 1'b1, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h7F, 1'b1, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'hC8, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h33, 1'b1, 8'h33},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h40, 1'b1, 8'h40},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h90, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h70, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'hEE, 1'b1, 8'hEE},
		'{ROW_CFG, CFG_LINE_WIDTH,   16'h07FF, 8'h00, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'hFF, 1'b0, 8'h00},
		'{ROW_CFG, CFG_LINE_WIDTH,   16'd0,    8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_IMAGE_HEIGHT, 16'hFFFF, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_SPARE,        16'hFFFF, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_LINE_WIDTH,   16'd1024, 8'h00, 1'b0, 8'h00},
		'{ROW_PIX, CFG_LINE_WIDTH,   16'h0000, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd1,    8'h00, 1'b0, 8'h00},
		'{ROW_CFG, CFG_LINE_WIDTH,   16'd1,    8'h00, 1'b0, 8'h00}
	};

	error_diffusion_binarizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out)
	);

	always #10 clk = ~clk;

	initial begin
		foreach (err_row[i]) err_row[i] = '0;
	end

	// Clamp to the signed 10-bit error range
	function automatic logic signed [ERR_W-1:0] clamp_err(input int v);
		if (v < -512) begin
			return -10'sd512;
		end else if (v > 511) begin
			return 10'sd511;
		end
		return v[ERR_W-1:0];
	endfunction

	// Binarize one pixel, diffuse its error and advance the raster position
	function automatic logic [PIX_W-1:0] dither_pixel(input logic [PIX_W-1:0] p);
		int w, h, x, y, sum, q, e, res;
		bit inner, last_col;
		w = (width_reg < 3) ? 3 : (width_reg > MAX_LINE) ? MAX_LINE : int'(width_reg);
		h = (height_reg < 3) ? 3 : int'(height_reg);
		x = int'(col_pos);
		y = int'(row_pos);
		inner = (y != 0) && (y < h - 1);
		last_col = (x >= w - 1);
		res = int'(p);
		if (inner && x == 0) begin
			carry_err = '0;
			below_left = '0;
			below_mid = '0;
		end else if (inner && !last_col) begin
			sum = int'(p) + int'(err_row[x]) + int'(carry_err);
			q = (sum >= int'(THRESHOLD)) ? int'(WHITE) : 0;
			e = sum - q;
			carry_err = clamp_err(e * 7 / 16);
			if (x >= 2) err_row[x - 1] = clamp_err(int'(below_left) + e * 3 / 16);
			below_left = clamp_err(int'(below_mid) + e * 5 / 16);
			below_mid = clamp_err(e / 16);
			res = q;
		end else if (inner && last_col) begin
			// row end: flush the partial sum for the column before the border
			err_row[w - 2] = below_left;
		end
		if (last_col) begin
			col_pos = '0;
			if (y >= h - 1) begin
				row_pos = '0;
				foreach (err_row[i]) err_row[i] = '0;
			end else begin
				row_pos = 16'(y + 1);
			end
		end else begin
			col_pos = 10'(x + 1);
		end
		return res[PIX_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] next_pixel(input pattern_t pat, input int k);
		case (pat)
			PAT_NOISE:   return PIX_W'($urandom_range(255));
			PAT_MID:     return PIX_W'($urandom_range(112, 143));
			PAT_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			default:     return PIX_W'(k * 7);
		endcase
	endfunction

	function automatic logic [CDAT_W-1:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 6) return CDAT_W'($urandom_range(2));
		if (r < 9) return CDAT_W'(MAX_LINE);
		if (r < 12) return CDAT_W'($urandom_range(1025, 2047));
		if (r < 15) return CDAT_W'($urandom_range(25, 1023));
		// junk above the 11-bit field must be dropped
		if (r < 18) return {5'($urandom_range(31)), 11'($urandom_range(3, 24))};
		return CDAT_W'($urandom_range(3, 24));
	endfunction

	function automatic logic [CDAT_W-1:0] pick_height();
		int r;
		r = $urandom_range(99);
		if (r < 6) return CDAT_W'($urandom_range(2));
		if (r < 9) return 16'hFFFF;
		if (r < 12) return CDAT_W'($urandom_range(13, 65534));
		return CDAT_W'($urandom_range(3, 12));
	endfunction

	task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] got,
			input logic [PIX_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at %0t: %s: pixel_out %02h, want %02h", $time, what, got, want);
	endtask

	// Drop the input and wait until every owed pixel has come out
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
	endtask

	// Offer one pixel beat, with random gaps, and record what it must give
	task automatic send_pixel(input logic [PIX_W-1:0] p, input logic known,
			input logic [PIX_W-1:0] want);
		logic [PIX_W-1:0] predicted;
		@(negedge clk);
		while (tx_gaps && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = dither_pixel(p);
		pending_pixels.push_back(known ? want : predicted);
	endtask

	// Write one register while the block is idle
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_LINE_WIDTH) width_reg = val[LW_W-1:0];
		else if (idx == CFG_IMAGE_HEIGHT) height_reg = val[IH_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= rx_gaps && ($urandom_range(99) < 23);
		end
	end

	// Check each output beat against the oldest owed pixel
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0)
				flag_mismatch("output beat with nothing owed", pixel_out, 8'h00);
			else if (pixel_out !== pending_pixels[0])
				flag_mismatch("wrong pixel", pixel_out, pending_pixels.pop_front());
			else
				void'(pending_pixels.pop_front());
		end
	end

	initial begin
		#(4_000_000);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int random_sent, ph, n, limit, images_left;
		pattern_t pat;
		bit broken;
		random_sent = 0;
		ph = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part
		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg == ROW_CFG)
				write_reg(directed_steps[i].idx, directed_steps[i].val);
			else
				send_pixel(directed_steps[i].pix, directed_steps[i].known,
					directed_steps[i].want);
		end

		// Random phases: mostly whole images, some cut short mid-image
		while (random_sent < RANDOM_ITEMS) begin
			tx_gaps = !((ph >= 4 && ph < 9) || ph == 2);
			rx_gaps = !(ph >= 4 && ph < 9);
			case ($urandom_range(3))
				0: write_reg(CFG_LINE_WIDTH, pick_width());
				1: write_reg(CFG_IMAGE_HEIGHT, pick_height());
				2: begin
					write_reg(CFG_IMAGE_HEIGHT, pick_height());
					write_reg(CFG_LINE_WIDTH, pick_width());
				end
				default: begin
					write_reg(CFG_LINE_WIDTH, pick_width());
					write_reg(CFG_IMAGE_HEIGHT, pick_height());
				end
			endcase
			pat = pattern_t'($urandom_range(3));
			broken = (ph != 2) && ($urandom_range(4) == 0);
			limit = broken ? $urandom_range(1, 60) : 400;
			images_left = (ph == 2) ? 2 : $urandom_range(1, 2);
			// long receiver hold-off while the sender keeps offering beats
			if (ph == 2) hold_req = 1'b1;
			n = 0;
			while (n < limit && images_left > 0) begin
				send_pixel(next_pixel(pat, n), 1'b0, 8'h00);
				n++;
				random_sent++;
				if (col_pos == 0 && row_pos == 0) images_left--;
				// pause the sender until everything owed has come out
				if (n == 15 && ph % 5 == 3) drain_results();
			end
			ph++;
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
